@@ src/spsk_pkg.sv @@
// package for skeletal pose and skinning block
// holds the sequencer operation codes and fixed-point helpers; no dependencies
package spsk_pkg;

    // opcode values of a request
    localparam logic OP_JOINT  = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    localparam int POS_W  = 32;
    localparam int ACC_W  = 48;
    localparam int BIAS_W = 17;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sd2147483647;
            lo = -66'sd2147483648;
            if (x > hi) sat32 = 32'sh7fffffff;
            else if (x < lo) sat32 = 32'sh80000000;
            else sat32 = x[31:0];
        end
    endfunction

    // saturate a 66-bit signed value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sh0_7fff_ffff_ffff;
            lo = -66'sh0_8000_0000_0000;
            if (x > hi) sat48 = 48'sh7fff_ffff_ffff;
            else if (x < lo) sat48 = 48'sh8000_0000_0000;
            else sat48 = x[47:0];
        end
    endfunction

endpackage

@@ src/skeletal_pose_and_skinning.sv @@
// Skeletal pose and linear blend skinning over one shared 32x32 multiplier.
// Requests on the input channel are joint loads (opcode 0) or skinning
// weights (opcode 1). Depends on spsk_pkg.
//
// Usage:
//   input channel  i_valid / o_stall, fields i_opcode .. i_last_weight
//   output channel o_valid / i_stall, fields o_vert_x/y/z
// A request is taken when i_valid is high and o_stall low. The block then
// holds o_stall high while a microcoded sequencer steps one multiplier:
// one product per cycle, each followed by a register and an add. A joint
// with a parent holds o_stall through a table read, 15 rotation products,
// 16 quaternion products and a write back; a root joint through the write
// back; a weight through a table read, 15 rotation products and 3 bias
// products, or the table read alone when its joint lies outside the table.
// No new request is taken until the last one is done. A weight marked last
// loads the output register; a further last weight waits until the output
// register is free, so a stalled receiver stretches that weight by the stall.
// Reset clears the sequencer, the accumulator and the output valid; the
// joint table is undefined until written.
module skeletal_pose_and_skinning
    import spsk_pkg::*;
#(
    parameter int MAX_JOINTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_opcode,
    input  logic [7:0]          i_joint_index,
    input  logic signed [8:0]   i_parent_index,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic signed [31:0]  i_quat_w,
    input  logic signed [31:0]  i_quat_x,
    input  logic signed [31:0]  i_quat_y,
    input  logic signed [31:0]  i_quat_z,
    input  logic [16:0]         i_bias,
    input  logic                i_last_weight,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_vert_x,
    output logic signed [31:0]  o_vert_y,
    output logic signed [31:0]  o_vert_z
);

    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_LOAD, S_UV, S_UUV, S_FIN, S_QUAT, S_WRITE,
        S_BIAS, S_ACC, S_EMIT
    } t_state;

    // joint table, one memory of 7 words per entry
    logic [7*POS_W-1:0] r_mem [MAX_JOINTS];
    logic [7*POS_W-1:0] r_rd;

    t_state r_state;
    logic   r_op, r_last, r_valid_j;
    logic [AW-1:0] r_ji;
    logic [16:0]   r_bias;
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_lq [4];
    logic signed [31:0] r_q [4];   // parent or joint quaternion
    logic signed [31:0] r_p [3];   // parent or joint position
    logic signed [31:0] r_uv [3];
    logic signed [31:0] r_uuv [3];
    logic signed [31:0] r_res [7]; // new pose: pos x,y,z then quat w,x,y,z
    logic signed [65:0] r_sum;
    logic signed [63:0] r_prod;
    logic               r_pv;      // product register holds a term
    logic               r_neg;     // sign of that term
    logic [4:0]         r_step;
    logic signed [47:0] r_acc [3];
    logic               r_ovalid;
    logic signed [31:0] r_out [3];

    // operand selection for the shared multiplier
    logic signed [31:0] w_a, w_b;
    logic               w_neg, w_term;
    logic signed [63:0] w_mul;
    logic signed [65:0] w_mq;

    // index of the term landing this cycle
    logic [1:0]         w_li;      // fin and bias lanes
    logic [1:0]         w_ci;      // cross product component
    logic [2:0]         w_qi;      // quaternion result word
    logic               w_jok, w_pok, w_emit;

    always_comb begin
        w_a = '0; w_b = '0; w_neg = 1'b0; w_term = 1'b0;
        case (r_state)
            S_UV, S_UUV: begin
                // cross product u x v: term pair per component
                w_term = 1'b1;
                case (r_step[2:0])
                    3'd0: begin w_a = r_q[2]; w_b = (r_state == S_UV) ? r_v[2] : r_uv[2]; end
                    3'd1: begin w_a = r_q[3]; w_b = (r_state == S_UV) ? r_v[1] : r_uv[1];
                                w_neg = 1'b1; end
                    3'd2: begin w_a = r_q[3]; w_b = (r_state == S_UV) ? r_v[0] : r_uv[0]; end
                    3'd3: begin w_a = r_q[1]; w_b = (r_state == S_UV) ? r_v[2] : r_uv[2];
                                w_neg = 1'b1; end
                    3'd4: begin w_a = r_q[1]; w_b = (r_state == S_UV) ? r_v[1] : r_uv[1]; end
                    3'd5: begin w_a = r_q[2]; w_b = (r_state == S_UV) ? r_v[0] : r_uv[0];
                                w_neg = 1'b1; end
                    default: w_term = 1'b0;
                endcase
            end
            S_FIN: begin
                if (r_step < 5'd3) begin
                    w_term = 1'b1; w_a = r_uv[r_step[1:0]]; w_b = r_q[0];
                end
            end
            S_QUAT: begin
                w_term = r_step < 5'd16;
                w_a = r_q[r_step[1:0]];
                case ({r_step[3:2], r_step[1:0]})
                    4'b0000: begin w_b = r_lq[0]; end
                    4'b0001: begin w_b = r_lq[1]; w_neg = 1'b1; end
                    4'b0010: begin w_b = r_lq[2]; w_neg = 1'b1; end
                    4'b0011: begin w_b = r_lq[3]; w_neg = 1'b1; end
                    4'b0100: begin w_b = r_lq[1]; end
                    4'b0101: begin w_b = r_lq[0]; end
                    4'b0110: begin w_b = r_lq[3]; end
                    4'b0111: begin w_b = r_lq[2]; w_neg = 1'b1; end
                    4'b1000: begin w_b = r_lq[2]; end
                    4'b1001: begin w_b = r_lq[3]; w_neg = 1'b1; end
                    4'b1010: begin w_b = r_lq[0]; end
                    4'b1011: begin w_b = r_lq[1]; end
                    4'b1100: begin w_b = r_lq[3]; end
                    4'b1101: begin w_b = r_lq[2]; end
                    4'b1110: begin w_b = r_lq[1]; w_neg = 1'b1; end
                    default: begin w_b = r_lq[0]; end
                endcase
            end
            S_BIAS: begin
                if (r_step < 5'd3) begin
                    w_term = 1'b1;
                    w_a = r_res[{1'b0, r_step[1:0]}]; w_b = {15'd0, r_bias};
                end
            end
            default: ;
        endcase
    end

    assign w_mul = w_a * w_b;
    // rounded shift of the registered product
    assign w_mq = r_op && (r_state == S_BIAS || r_state == S_ACC)
                ? 66'((r_prod + 64'sd32768) >>> 16)
                : 66'((r_prod + 64'sd536870912) >>> 30);

    assign w_li = r_step[1:0] - 2'd1;
    assign w_ci = r_step[2:1] - 2'd1;
    assign w_qi = r_step[4:2] + 3'd2;

    // range checks of the request indexes
    assign w_jok = {3'b000, i_joint_index} < 11'(MAX_JOINTS);
    assign w_pok = !i_parent_index[8] && ({3'b000, i_parent_index[7:0]} < 11'(MAX_JOINTS));

    // output register is loaded when free or drained this cycle
    assign w_emit = (r_state == S_EMIT) && r_last && (!r_ovalid || !i_stall);

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_vert_x = r_out[0];
    assign o_vert_y = r_out[1];
    assign o_vert_z = r_out[2];

    // table port: registered read in every idle cycle, one write
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE)
            r_rd <= r_mem[AW'(i_opcode ? i_joint_index : i_parent_index[7:0])];
        if (r_state == S_WRITE)
            r_mem[r_ji] <= {r_res[0], r_res[1], r_res[2], r_res[3], r_res[4], r_res[5],
                            r_res[6]};
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
            for (int i = 0; i < 3; i++) r_acc[i] <= '0;
        end else begin
            if (w_emit) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            r_pv   <= w_term;
            r_neg  <= w_neg;
            r_prod <= w_mul;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_opcode; r_last <= i_last_weight; r_bias <= i_bias;
                        r_v[0] <= i_pos_x; r_v[1] <= i_pos_y; r_v[2] <= i_pos_z;
                        r_lq[0] <= i_quat_w; r_lq[1] <= i_quat_x;
                        r_lq[2] <= i_quat_y; r_lq[3] <= i_quat_z;
                        r_ji <= AW'(i_joint_index);
                        r_step <= '0;
                        r_sum <= '0;
                        if (i_opcode == OP_WEIGHT) begin
                            r_valid_j <= w_jok;
                            r_state <= S_READ;
                        end else if (!w_jok) begin
                            r_state <= S_IDLE;
                        end else if (!w_pok) begin
                            r_res[0] <= i_pos_x; r_res[1] <= i_pos_y; r_res[2] <= i_pos_z;
                            r_res[3] <= i_quat_w; r_res[4] <= i_quat_x;
                            r_res[5] <= i_quat_y; r_res[6] <= i_quat_z;
                            r_state <= S_WRITE;
                        end else begin
                            r_valid_j <= 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_LOAD;
                S_LOAD: begin
                    r_p[0] <= r_rd[7*32-1 -: 32]; r_p[1] <= r_rd[6*32-1 -: 32];
                    r_p[2] <= r_rd[5*32-1 -: 32]; r_q[0] <= r_rd[4*32-1 -: 32];
                    r_q[1] <= r_rd[3*32-1 -: 32]; r_q[2] <= r_rd[2*32-1 -: 32];
                    r_q[3] <= r_rd[31:0];
                    r_step <= '0;
                    if (r_op == OP_WEIGHT && !r_valid_j) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_UV;
                    end
                end
                S_UV, S_UUV: begin
                    // products issue on steps 0..5, sums land in the cycle after
                    if (r_pv) begin
                        if (r_neg) begin
                            if (r_state == S_UV) r_uv[w_ci] <= sat32(r_sum - w_mq);
                            else r_uuv[w_ci] <= sat32(r_sum - w_mq);
                            r_sum <= '0;
                        end else begin
                            r_sum <= w_mq;
                        end
                    end
                    if (r_step == 5'd6) begin
                        r_step <= '0;
                        r_state <= (r_state == S_UV) ? S_UUV : S_FIN;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_FIN: begin
                    // r = v + 2*(uv*w + uuv), then add joint position
                    if (r_pv) begin
                        r_res[{1'b0, w_li}] <= sat32(66'(r_p[w_li])
                            + 66'(sat32(66'(r_v[w_li])
                                + ((w_mq + 66'(r_uuv[w_li])) <<< 1))));
                    end
                    if (r_step == 5'd3) begin
                        r_step <= '0;
                        r_state <= (r_op == OP_WEIGHT) ? S_BIAS : S_QUAT;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_QUAT: begin
                    if (r_pv) begin
                        if (r_step[1:0] == 2'd0) begin
                            r_res[w_qi] <= sat32(r_neg ? r_sum - w_mq : r_sum + w_mq);
                            r_sum <= '0;
                        end else begin
                            r_sum <= r_neg ? r_sum - w_mq : r_sum + w_mq;
                        end
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd16) r_state <= S_WRITE;
                end
                S_WRITE: r_state <= S_IDLE;
                S_BIAS: begin
                    if (r_pv)
                        r_acc[w_li] <= sat48(66'(r_acc[w_li]) + w_mq);
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd3) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (w_emit) begin
                        for (int i = 0; i < 3; i++) begin
                            r_out[i] <= sat32(66'(r_acc[i]));
                            r_acc[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
